// ===== hw/rtl/lru_key_value_cache_macros.svh =====
// Assertion helpers for the checker file.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Same-cycle implication.
`define LKV_ASSERT_NOW(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LKV_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lkv_pkg.sv =====
`timescale 1ns / 1ps

package lkv_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam int DATA_W       = 32;
  localparam int CFG_W        = 5;
  localparam int IN_DATA_W    = 2 * DATA_W;
  localparam int OUT_DATA_W   = 2 * DATA_W;
  localparam int OUT_USER_W   = 2;

  localparam logic [CFG_W-1:0]  CAP_RESET = CFG_W'(16);
  localparam logic [DATA_W-1:0] READ_MISS = {DATA_W{1'b1}};

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  typedef struct packed {
    logic compare;
    logic update;
  } lkv_ctl_t;

endpackage

// ===== hw/rtl/lkv_cell.sv =====
`timescale 1ns / 1ps

module lkv_cell #(
  parameter int KEY_BITS = 32,
  parameter int VAL_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                compare_en,
  input  logic [KEY_BITS-1:0] cmp_key,
  input  logic                shift_en,
  input  logic                in_valid,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [VAL_BITS-1:0] in_value,
  output logic                valid,
  output logic [KEY_BITS-1:0] key,
  output logic [VAL_BITS-1:0] value,
  output logic                match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (compare_en) begin
        match <= valid && (key == cmp_key);
      end
      if (shift_en) begin
        valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      key   <= in_key;
      value <= in_value;
    end
  end

endmodule

// ===== hw/rtl/lkv_chain.sv =====
`timescale 1ns / 1ps

module lkv_chain #(
  parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF,
  parameter int OCC_W    = $clog2(ENTRIES + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lkv_pkg::lkv_ctl_t         ctl,
  input  logic [KEY_BITS-1:0]       cmp_key,
  input  logic [OCC_W-1:0]          shift_pos,
  input  logic [KEY_BITS-1:0]       new_key,
  input  logic [lkv_pkg::DATA_W-1:0] new_value,
  input  logic [OCC_W-1:0]          lru_pos,
  output logic                      hit,
  output logic [OCC_W-1:0]          found_pos,
  output logic [lkv_pkg::DATA_W-1:0] found_value,
  output logic [KEY_BITS-1:0]       lru_key
);
  import lkv_pkg::*;

  logic                cv   [ENTRIES];
  logic [KEY_BITS-1:0] ck   [ENTRIES];
  logic [DATA_W-1:0]   cval [ENTRIES];
  logic                cm   [ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                lv;
    logic [KEY_BITS-1:0] lk;
    logic [DATA_W-1:0]   lval;
    logic                sh;

    if (i == 0) begin : g_head
      assign lv   = 1'b1;
      assign lk   = new_key;
      assign lval = new_value;
    end else begin : g_body
      assign lv   = cv[i-1];
      assign lk   = ck[i-1];
      assign lval = cval[i-1];
    end

    assign sh = ctl.update && (OCC_W'(i) <= shift_pos);

    lkv_cell #(
      .KEY_BITS(KEY_BITS),
      .VAL_BITS(DATA_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .compare_en(ctl.compare),
      .cmp_key   (cmp_key),
      .shift_en  (sh),
      .in_valid  (lv),
      .in_key    (lk),
      .in_value  (lval),
      .valid     (cv[i]),
      .key       (ck[i]),
      .value     (cval[i]),
      .match     (cm[i])
    );
  end

  // keys are unique among valid cells, so at most one match is set
  always_comb begin
    hit         = 1'b0;
    found_pos   = '0;
    found_value = '0;
    lru_key     = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit         = hit | cm[i];
      found_pos   = found_pos | (cm[i] ? OCC_W'(i) : '0);
      found_value = found_value | (cm[i] ? cval[i] : '0);
      lru_key     = lru_key | ((OCC_W'(i) == lru_pos) ? ck[i] : '0);
    end
  end

endmodule

// ===== hw/rtl/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Beat fields
// s_*      in   tuser: func; tdata: lookup_key, write_value
// m_*      out  tuser: hit, evicted; tdata: read_value, evicted_key
// cfg_*    in   cfg_data: capacity_in_use
//
// The accept cycle latches compare results in every cell; in the EXEC state the
// cell row shifts (not on a get miss) and the output register loads.
// That step holds while the output register is full and not taken.
// Reset clears valid bits and occupancy and sets capacity to 16; no clearing pass.
// Config writes are taken every cycle.

module lru_key_value_cache #(
  parameter int ENTRIES  = lkv_pkg::ENTRIES_DEF,
  parameter int KEY_BITS = lkv_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [31:0] lookup_key, [63:32] write_value
  input  logic [lkv_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] func
  input  logic [0:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] read_value, [63:32] evicted_key
  output logic [lkv_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] hit, [1] evicted
  output logic [lkv_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lkv_pkg::CFG_W-1:0]      cfg_data
);
  import lkv_pkg::*;

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = ((OCC_W > CFG_W) ? OCC_W : CFG_W) + 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                state;
  logic [CFG_W-1:0]    cap;
  logic [OCC_W-1:0]    occ;
  logic [OCC_W-1:0]    occ_next;
  logic                item_set;
  logic [KEY_BITS-1:0] item_key;
  logic [DATA_W-1:0]   item_value;

  logic [KEY_BITS-1:0] key_in;
  logic                accept;
  logic                go;
  lkv_ctl_t            ctl;

  logic                hit;
  logic [OCC_W-1:0]    found_pos;
  logic [DATA_W-1:0]   found_value;
  logic [KEY_BITS-1:0] lru_key;
  logic [DATA_W-1:0]   lru_key32;

  logic                shift;
  logic [OCC_W-1:0]    pos;
  logic [DATA_W-1:0]   new_value;
  logic [DATA_W-1:0]   res_read;
  logic                res_ev;
  logic [DATA_W-1:0]   res_evkey;

  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    eff_cap;
  logic                full;

  logic                out_hit;
  logic                out_ev;
  logic [DATA_W-1:0]   out_read;
  logic [DATA_W-1:0]   out_evkey;

  if (KEY_BITS <= DATA_W) begin : g_key_narrow
    assign key_in = s_tdata[KEY_BITS-1:0];
    if (KEY_BITS == DATA_W) begin : g_same
      assign lru_key32 = lru_key;
    end else begin : g_ext
      assign lru_key32 = {{(DATA_W - KEY_BITS){1'b0}}, lru_key};
    end
  end else begin : g_key_wide
    assign key_in    = {{(KEY_BITS - DATA_W){1'b0}}, s_tdata[DATA_W-1:0]};
    assign lru_key32 = lru_key[DATA_W-1:0];
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign go        = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign cap_ext = CMP_W'(cap);
  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end
  end
  assign full = (CMP_W'(occ) >= eff_cap);

  always_comb begin
    shift     = 1'b0;
    pos       = found_pos;
    new_value = item_value;
    res_read  = '0;
    res_ev    = 1'b0;
    res_evkey = '0;
    occ_next  = occ;
    if (hit) begin
      shift = 1'b1;
      if (item_set == FUNC_GET) begin
        new_value = found_value;
        res_read  = found_value;
      end
    end else if (item_set == FUNC_GET) begin
      res_read = READ_MISS;
    end else begin
      shift = 1'b1;
      if (full) begin
        pos       = occ - OCC_W'(1);
        res_ev    = 1'b1;
        res_evkey = lru_key32;
      end else begin
        pos      = occ;
        occ_next = occ + OCC_W'(1);
      end
    end
  end

  assign ctl.compare = accept;
  assign ctl.update  = go && shift;

  lkv_chain #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS),
    .OCC_W   (OCC_W)
  ) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cmp_key    (key_in),
    .shift_pos  (pos),
    .new_key    (item_key),
    .new_value  (new_value),
    .lru_pos    (occ - OCC_W'(1)),
    .hit        (hit),
    .found_pos  (found_pos),
    .found_value(found_value),
    .lru_key    (lru_key)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cap      <= CAP_RESET;
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (go) begin
        occ      <= occ_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_set   <= s_tuser[0];
      item_key   <= key_in;
      item_value <= s_tdata[IN_DATA_W-1:DATA_W];
    end
    if (go) begin
      out_hit   <= hit;
      out_ev    <= res_ev;
      out_read  <= res_read;
      out_evkey <= res_evkey;
    end
  end

  assign m_tdata = {out_evkey, out_read};
  assign m_tuser = {out_ev, out_hit};

endmodule

// ===== hw/rtl/lkv_checker.sv =====
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"

module lkv_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lkv_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [lkv_pkg::OUT_USER_W-1:0] m_tuser
);

  `LKV_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  `LKV_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "input ready right after an accepted beat")

  `LKV_ASSERT_NOW(a_evict_not_hit, clk, rst, m_tvalid, !(m_tuser[0] && m_tuser[1]), "eviction flagged on a hit")

  `LKV_ASSERT_NOW(a_evict_read_zero, clk, rst, m_tvalid && m_tuser[1], m_tdata[31:0] == 32'd0, "eviction with nonzero read value")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

// ===== tb/lru_cache_checker.sv =====
`timescale 1ns / 1ps

module lru_cache_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // [31:0] lookup_key, [63:32] write_value
  input  logic [lkv_pkg::IN_DATA_W-1:0]  s_tdata,
  // [0] func
  input  logic [0:0]                     s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // [31:0] read_value, [63:32] evicted_key
  input  logic [lkv_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] hit, [1] evicted
  input  logic [lkv_pkg::OUT_USER_W-1:0] m_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lkv_pkg::CFG_W-1:0]      cfg_data,
  output int                             mismatches,
  output int                             pending
);
  import lkv_pkg::*;

  localparam int SLOTS = ENTRIES_DEF;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic  hit;
    word_t read_value;
    logic  evicted;
    word_t evicted_key;
  } reply_t;

  // slot 0 is most recent, slot fill-1 least recent
  word_t            slot_key [SLOTS];
  word_t            slot_val [SLOTS];
  int               fill = 0;
  logic [CFG_W-1:0] capacity = CAP_RESET;
  reply_t           expected_replies [$];
  int               err_cnt = 0;

  function automatic void move_to_front(int pos);
    word_t k;
    word_t v;
    k = slot_key[pos];
    v = slot_val[pos];
    for (int i = pos; i > 0; i--) begin
      slot_key[i] = slot_key[i-1];
      slot_val[i] = slot_val[i-1];
    end
    slot_key[0] = k;
    slot_val[0] = v;
  endfunction

  function automatic reply_t access_cache(logic func, word_t key, word_t wval);
    reply_t r;
    int     found;
    int     last;
    int     limit;
    r = '0;
    found = -1;
    if (capacity == 0) limit = 1;
    else if (capacity > SLOTS) limit = SLOTS;
    else limit = int'(capacity);
    for (int i = 0; i < fill; i++) begin
      if (found < 0 && slot_key[i] == key) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (func == FUNC_SET) slot_val[found] = wval;
      else r.read_value = slot_val[found];
      move_to_front(found);
    end else if (func == FUNC_GET) begin
      r.read_value = READ_MISS;
    end else begin
      if (fill >= limit && fill > 0) begin
        r.evicted = 1'b1;
        r.evicted_key = slot_key[fill-1];
        last = fill - 1;
      end else begin
        last = fill;
        fill++;
      end
      slot_key[last] = key;
      slot_val[last] = wval;
      move_to_front(last);
    end
    return r;
  endfunction

  function automatic void note_mismatch(string what, reply_t e, reply_t g);
    err_cnt++;
    if (err_cnt <= 10)
      $display("%s: exp hit=%0b rd=%h ev=%0b evk=%h | got hit=%0b rd=%h ev=%0b evk=%h",
               what, e.hit, e.read_value, e.evicted, e.evicted_key,
               g.hit, g.read_value, g.evicted, g.evicted_key);
  endfunction

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst) begin
      capacity = CAP_RESET;
      fill = 0;
      expected_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.hit = m_tuser[0];
        got.evicted = m_tuser[1];
        got.read_value = m_tdata[31:0];
        got.evicted_key = m_tdata[63:32];
        if (expected_replies.size() == 0) begin
          note_mismatch("unexpected beat", '0, got);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) note_mismatch("result mismatch", want, got);
        end
      end
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      if (s_tvalid && s_tready)
        expected_replies.push_back(access_cache(s_tuser[0], s_tdata[31:0], s_tdata[63:32]));
    end
    pending <= expected_replies.size();
    mismatches <= err_cnt;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lkv_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data = '0;

  int mismatches;
  int pending;
  int idle_pct = 0;
  int quiet_cycles = 0;

  logic [DATA_W-1:0] key_pool [32];
  int                pool_n;

  initial begin
    forever #5 clk = ~clk;
  end

  lru_key_value_cache uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  lru_cache_checker chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_idle();
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send(logic func, logic [DATA_W-1:0] key, logic [DATA_W-1:0] wval);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= func;
    s_tdata  <= {wval, key};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CFG_W-1:0] cap);
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(logic [CFG_W-1:0] cap, int n_items, int idle);
    int               eff;
    logic [DATA_W-1:0] key;
    drain();
    set_capacity(cap);
    idle_pct = idle;
    if (cap == 0) eff = 1;
    else if (cap > ENTRIES_DEF) eff = ENTRIES_DEF;
    else eff = int'(cap);
    // a few more keys than slots: hits plus steady evictions
    pool_n = eff + $urandom_range(1, 4);
    for (int i = 0; i < pool_n; i++) begin
      key_pool[i] = $urandom();
      if ($urandom_range(0, 3) == 0) begin
        case (i % 4)
          0: key_pool[i] = 32'h8000_0000;
          1: key_pool[i] = 32'h7FFF_FFFF;
          2: key_pool[i] = '1;
          default: key_pool[i] = '0;
        endcase
      end
    end
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 99) < 80) key = key_pool[$urandom_range(0, pool_n - 1)];
      else key = $urandom();
      send(logic'($urandom_range(0, 1)), key, $urandom());
    end
  endtask

  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = pick_idle();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_W-1:0] caps [9];
    int               idles [9];
    caps  = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd17, 5'd8, 5'd5, 5'd0};
    idles = '{40, 30, 0, 50, 30, 40, 30, 60, 30};
    caps[8] = CFG_W'($urandom_range(0, 31));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset capacity, empty cache, extreme keys and values
    send(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
    send(FUNC_SET, 32'h8000_0000, 32'h7FFF_FFFF);
    send(FUNC_SET, 32'h7FFF_FFFF, 32'h8000_0000);
    send(FUNC_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(FUNC_SET, 32'h0000_0000, 32'h0000_0000);
    send(FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send(FUNC_GET, 32'h8000_0000, 32'h1234_5678);
    send(FUNC_SET, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    send(FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send(FUNC_GET, 32'h0000_0001, 32'hFFFF_FFFF);

    // capacity dropped below occupancy
    drain();
    set_capacity(5'd2);
    send(FUNC_SET, 32'h0000_0011, 32'h0000_0001);
    send(FUNC_SET, 32'h0000_0022, 32'h0000_0002);
    send(FUNC_GET, 32'h0000_0011, 32'h0000_0000);
    send(FUNC_SET, 32'h0000_0033, 32'h0000_0003);

    // zero capacity acts as one
    drain();
    set_capacity(5'd0);
    send(FUNC_SET, 32'h0000_0044, 32'hDEAD_BEEF);
    send(FUNC_SET, 32'h0000_0055, 32'hCAFE_F00D);
    send(FUNC_GET, 32'h0000_0055, 32'h0000_0000);
    send(FUNC_GET, 32'h0000_0044, 32'h0000_0000);

    for (int p = 0; p < 9; p++) run_random(caps[p], 70, idles[p]);

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
